FILE: design/pgls_pkg.sv
package pgls_pkg;

    localparam int PIXELS     = 4096;
    localparam int LABELS     = 4;
    localparam int NEIGHBOURS = 4;
    localparam int PIX_W      = 12;
    localparam int LAB_W      = 2;
    localparam int CNT_W      = 16;
    localparam int CIDX_W     = PIX_W + LAB_W;
    localparam int CNT_DEPTH  = PIXELS * LABELS;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_GIBBS   = 2'd1;
    localparam logic [1:0] OP_NODATA  = 2'd2;
    localparam logic [1:0] OP_CLASSIFY = 2'd3;

    localparam logic [2:0] REG_BETA   = 3'd0;
    localparam logic [2:0] REG_PRIOR0 = 3'd1;
    localparam logic [2:0] REG_PRIOR1 = 3'd2;
    localparam logic [2:0] REG_PRIOR2 = 3'd3;
    localparam logic [2:0] REG_PRIOR3 = 3'd4;

    localparam logic signed [15:0] IMPOSSIBLE = 16'sh8000;

    function automatic logic [16:0] pow2_frac(input logic [3:0] k);
        logic [16:0] r;
        begin
            case (k)
                4'd0:  r = 17'd65536;
                4'd1:  r = 17'd62757;
                4'd2:  r = 17'd60097;
                4'd3:  r = 17'd57549;
                4'd4:  r = 17'd55109;
                4'd5:  r = 17'd52773;
                4'd6:  r = 17'd50535;
                4'd7:  r = 17'd48393;
                4'd8:  r = 17'd46341;
                4'd9:  r = 17'd44376;
                4'd10: r = 17'd42495;
                4'd11: r = 17'd40693;
                4'd12: r = 17'd38968;
                4'd13: r = 17'd37316;
                4'd14: r = 17'd35734;
                default: r = 17'd34219;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/potts_gibbs_label_sampler.sv
// potts gibbs label sampler
// s_axis: one request per pixel operation; tdata fields from bit 0: op[1:0],
//   pixel[13:2], nbr_a..nbr_d (13 bits each) [65:14], loglike0..3 [129:66],
//   uniform[145:130], init_label[147:146], zero fill to 152 bits
// m_axis: one result per request; tdata from bit 0: new_label[1:0],
//   visit_count[17:2], no_choice[18], zero fill to 24 bits
// apb: beta at 0x00, prior_label0..3 at 0x04..0x10, reads return values
// a request is processed by a sequencer around one shared multiply unit:
//   neighbour label reads, then scoring of each label, a weight for each
//   label, the draw compare label by label until a hit or the last label
//   (or a read of the pixel's own label when no label is possible), and a
//   read plus write of the counter; a label write goes straight to the counter
//   read; the next request is taken only after the result is accepted
// s_tready is low while a request is in flight and while a result waits
// after reset the counter memory is swept to zero, one entry per cycle,
//   with s_tready low; label store swept at the same time
// a stalled m_tready holds the result and the block takes no new request
module potts_gibbs_label_sampler
    import pgls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // op, pixel, nbr_a..d, loglike0..3, uniform, init_label
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // new_label, visit_count, no_choice
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_NBR   = 4'd2;
    localparam logic [3:0] ST_NBRW  = 4'd3;
    localparam logic [3:0] ST_SCORE = 4'd4;
    localparam logic [3:0] ST_WGT   = 4'd5;
    localparam logic [3:0] ST_DRAW  = 4'd6;
    localparam logic [3:0] ST_LBLRD = 4'd7;
    localparam logic [3:0] ST_CRD   = 4'd8;
    localparam logic [3:0] ST_CWAIT = 4'd9;
    localparam logic [3:0] ST_CWR   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;
    localparam logic [3:0] ST_PRE   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [CIDX_W:0] clr_reg, clr_next;

    logic [15:0] beta_reg;
    logic [15:0] prior_reg [LABELS];

    logic [1:0]  op_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [12:0] nbr_reg [NEIGHBOURS];
    logic signed [15:0] ll_reg [LABELS];
    logic [15:0] uni_reg;
    logic [LAB_W-1:0] init_reg;

    logic [LAB_W-1:0] lbl_mem [PIXELS];
    logic [CNT_W-1:0] cnt_mem [CNT_DEPTH];
    logic [LAB_W-1:0] lbl_rd_reg;
    logic [CNT_W-1:0] cnt_rd_reg;

    logic [2:0] ncnt_reg [LABELS];
    logic signed [18:0] score_reg [LABELS];
    logic [LABELS-1:0] poss_reg;
    logic signed [18:0] max_reg;
    logic any_reg;
    logic [16:0] w_reg [LABELS];
    logic [18:0] sum_reg;
    logic [18:0] cum_reg;
    logic [2:0] idx_reg;
    logic [LAB_W-1:0] pick_reg;
    logic nochoice_reg;
    logic [CNT_W-1:0] outcnt_reg;
    logic [LAB_W-1:0] outlab_reg;

    // shared multiply unit
    logic [17:0] mul_a;
    logic [18:0] mul_b;
    logic [36:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [LAB_W-1:0] ci;
    assign ci = idx_reg[LAB_W-1:0];

    logic [12:0] cur_nbr;
    assign cur_nbr = nbr_reg[idx_reg[1:0]];

    logic signed [18:0] sc_val;
    logic sc_poss;
    logic [18:0] d_val;
    logic [16:0] w_val;
    logic [LAB_W-1:0] lab_sel;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        sc_val = '0;
        sc_poss = 1'b0;
        d_val = '0;
        w_val = '0;
        case (state_reg)
            ST_SCORE:
            begin
                mul_a = {2'b0, beta_reg};
                mul_b = {16'b0, ncnt_reg[ci]};
                if (op_reg == OP_CLASSIFY)
                    sc_val = 19'(ll_reg[ci]) + 19'(signed'(prior_reg[ci]));
                else if (op_reg == OP_GIBBS)
                    sc_val = 19'(ll_reg[ci]) + signed'({1'b0, mul_p[21:4]});
                else
                    sc_val = signed'({1'b0, mul_p[21:4]});
                sc_poss = (op_reg == OP_NODATA) || (ll_reg[ci] != IMPOSSIBLE);
            end
            ST_WGT:
            begin
                d_val = 19'(max_reg - score_reg[ci]);
                mul_a = d_val[17:0];
                mul_b = 19'd369;
                if ((mul_p[36:16] >= 21'd17) || d_val[18] || !poss_reg[ci])
                    w_val = '0;
                else
                    w_val = pow2_frac(mul_p[15:12]) >> mul_p[20:16];
            end
            ST_DRAW:
            begin
                mul_a = {2'b0, uni_reg};
                mul_b = sum_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign lab_sel = (op_reg == OP_WRITE) ? init_reg : pick_reg;

    logic [18:0] cum_new;
    assign cum_new = cum_reg + {2'b0, w_reg[ci]};

    logic draw_hit;
    assign draw_hit = mul_p < 37'({cum_new, 16'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            beta_reg  <= '0;
            for (int i = 0; i < LABELS; i++)
                prior_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[4:2])
                    REG_BETA:   beta_reg <= pwdata[15:0];
                    REG_PRIOR0: prior_reg[0] <= pwdata[15:0];
                    REG_PRIOR1: prior_reg[1] <= pwdata[15:0];
                    REG_PRIOR2: prior_reg[2] <= pwdata[15:0];
                    REG_PRIOR3: prior_reg[3] <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (CIDX_W+1)'(CNT_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:  if (s_tvalid) state_next = ST_PRE;
            ST_PRE:   state_next = (op_reg == OP_WRITE) ? ST_CRD : ST_NBR;
            ST_NBR:   state_next = ST_NBRW;
            ST_NBRW:  if (idx_reg == 3'(NEIGHBOURS)) state_next = ST_SCORE;
                      else state_next = ST_NBRW;
            ST_SCORE: if (idx_reg == 3'(LABELS - 1)) state_next = ST_WGT;
            ST_WGT:   if (idx_reg == 3'(LABELS - 1))
                          state_next = any_reg ? ST_DRAW : ST_LBLRD;
            ST_DRAW:  if (idx_reg == 3'(LABELS - 1) || draw_hit)
                          state_next = ST_CRD;
                      else state_next = ST_DRAW;
            ST_LBLRD: state_next = ST_CRD;
            ST_CRD:   state_next = ST_CWAIT;
            ST_CWAIT: state_next = ST_CWR;
            ST_CWR:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath
    logic hit_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            cnt_mem[clr_reg[CIDX_W-1:0]] <= '0;
            lbl_mem[clr_reg[PIX_W-1:0]] <= '0;
        end
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            op_reg  <= s_tdata[1:0];
            pix_reg <= s_tdata[13:2];
            for (int k = 0; k < NEIGHBOURS; k++)
                nbr_reg[k] <= s_tdata[14 + 13*k +: 13];
            for (int j = 0; j < LABELS; j++)
                ll_reg[j] <= s_tdata[66 + 16*j +: 16];
            uni_reg  <= s_tdata[145:130];
            init_reg <= s_tdata[147:146];
        end
        lbl_rd_reg <= lbl_mem[(state_reg == ST_LBLRD) ? pix_reg : cur_nbr[PIX_W-1:0]];
        case (state_reg)
            ST_PRE:
            begin
                idx_reg <= '0;
                for (int j = 0; j < LABELS; j++)
                    ncnt_reg[j] <= '0;
                hit_reg <= 1'b0;
                if (op_reg == OP_WRITE)
                begin
                    lbl_mem[pix_reg] <= init_reg;
                    pick_reg <= init_reg;
                end
            end
            ST_NBR:
            begin
                hit_reg <= !cur_nbr[12];
                idx_reg <= idx_reg + 1'b1;
            end
            ST_NBRW:
            begin
                if (hit_reg)
                    ncnt_reg[lbl_rd_reg] <= ncnt_reg[lbl_rd_reg] + 1'b1;
                hit_reg <= !cur_nbr[12];
                if (idx_reg == 3'(NEIGHBOURS))
                begin
                    idx_reg <= '0;
                    any_reg <= 1'b0;
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            ST_SCORE:
            begin
                score_reg[ci] <= sc_val;
                poss_reg[ci]  <= sc_poss;
                if (sc_poss && (!any_reg || sc_val > max_reg))
                begin
                    max_reg <= sc_val;
                    any_reg <= 1'b1;
                end
                idx_reg <= (idx_reg == 3'(LABELS - 1)) ? 3'd0 : idx_reg + 1'b1;
                sum_reg <= '0;
            end
            ST_WGT:
            begin
                w_reg[ci] <= w_val;
                sum_reg <= sum_reg + {2'b0, w_val};
                idx_reg <= (idx_reg == 3'(LABELS - 1)) ? 3'd0 : idx_reg + 1'b1;
                cum_reg <= '0;
                nochoice_reg <= !any_reg;
            end
            ST_DRAW:
            begin
                cum_reg <= cum_new;
                pick_reg <= ci;
                idx_reg <= idx_reg + 1'b1;
            end
            ST_LBLRD:
            begin
            end
            ST_CRD:
            begin
                if (nochoice_reg && op_reg != OP_WRITE)
                    pick_reg <= lbl_rd_reg;
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_PRE)
            nochoice_reg <= 1'b0;
        cnt_rd_reg <= cnt_mem[{pix_reg, lab_sel}];
        if (state_reg == ST_CWR)
        begin
            outlab_reg <= lab_sel;
            if (op_reg == OP_WRITE || nochoice_reg || cnt_rd_reg == '1)
                outcnt_reg <= cnt_rd_reg;
            else
            begin
                outcnt_reg <= cnt_rd_reg + 1'b1;
                cnt_mem[{pix_reg, lab_sel}] <= cnt_rd_reg + 1'b1;
            end
            if (op_reg != OP_WRITE && !nochoice_reg)
                lbl_mem[pix_reg] <= lab_sel;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'b0, nochoice_reg & (op_reg != OP_WRITE), outcnt_reg, outlab_reg};
    assign pready   = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_BETA:   prdata = {16'b0, beta_reg};
            REG_PRIOR0: prdata = {16'b0, prior_reg[0]};
            REG_PRIOR1: prdata = {16'b0, prior_reg[1]};
            REG_PRIOR2: prdata = {16'b0, prior_reg[2]};
            REG_PRIOR3: prdata = {16'b0, prior_reg[3]};
            default:    prdata = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_write_nochoice: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && op_reg == OP_WRITE |-> !m_tdata[18])
        else $error("write flagged no choice");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pgls_pkg::*;

    typedef struct packed {
        logic [1:0]  label;
        logic [15:0] count;
        logic        no_choice;
    } sample_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    potts_gibbs_label_sampler dut (.*);

    logic [151:0] pending_requests[$];
    sample_t      expected_samples[$];
    bit           calm = 1'b0;
    int           mismatches = 0;
    longint       cycles = 0;

    logic [1:0]  label_mem[PIXELS];
    logic [15:0] visit_mem[CNT_DEPTH];
    logic [15:0] beta_reg;
    logic [15:0] prior_reg[4];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint exp_weight(input longint d);
        longint t;
        longint frac[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                             46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
        t = (d * 369) >>> 8;
        if ((t >>> 8) >= 17)
            return 0;
        return frac[(t & 255) >>> 4] >>> (t >>> 8);
    endfunction

    task automatic predict_sample(input logic [151:0] d);
        logic [1:0]  op;
        logic [11:0] px;
        logic [12:0] nb;
        longint      score[4];
        longint      w[4];
        bit          ok[4];
        int          cnt[4];
        longint      ll, mx, total, cum;
        bit          any;
        int          pick;
        sample_t     s;
        op = d[1:0];
        px = d[13:2];
        cnt = '{0, 0, 0, 0};
        any = 0;
        mx = 0;
        total = 0;
        cum = 0;
        pick = 0;
        s.no_choice = 1'b0;
        if (op == OP_WRITE) begin
            label_mem[px] = d[147:146];
            s.label = d[147:146];
            s.count = visit_mem[{px, d[147:146]}];
            expected_samples.push_back(s);
            return;
        end
        for (int k = 0; k < 4; k++)
        begin
            nb = d[14 + 13*k +: 13];
            if (nb < PIXELS)
                cnt[label_mem[nb[11:0]]]++;
        end
        for (int j = 0; j < 4; j++)
        begin
            ll = longint'($signed(d[66 + 16*j +: 16]));
            if (op == OP_GIBBS)
                score[j] = ll + ((longint'(beta_reg) * cnt[j]) >>> 4);
            else if (op == OP_NODATA)
                score[j] = (longint'(beta_reg) * cnt[j]) >>> 4;
            else
                score[j] = ll + longint'($signed(prior_reg[j]));
            ok[j] = (op == OP_NODATA) || (ll != -32768);
            if (ok[j] && (!any || score[j] > mx))
            begin
                mx = score[j];
                any = 1;
            end
        end
        if (!any) begin
            s.label = label_mem[px];
            s.count = visit_mem[{px, label_mem[px]}];
            s.no_choice = 1'b1;
            expected_samples.push_back(s);
            return;
        end
        for (int j = 0; j < 4; j++)
        begin
            w[j] = ok[j] ? exp_weight(mx - score[j]) : 0;
            total += w[j];
        end
        for (int j = 3; j >= 0; j--)
        begin
            cum = 0;
            for (int i = 0; i <= j; i++)
                cum += w[i];
            if (longint'(d[145:130]) * total < cum * 65536)
                pick = j;
        end
        label_mem[px] = pick[1:0];
        if (visit_mem[{px, pick[1:0]}] != 16'hFFFF)
            visit_mem[{px, pick[1:0]}]++;
        s.label = pick[1:0];
        s.count = visit_mem[{px, pick[1:0]}];
        expected_samples.push_back(s);
    endtask

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            predict_sample(s_tdata);
        if (!s_tvalid || s_tready) begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 22))
            begin
                s_tdata <= pending_requests.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sample_t got, want;
        m_tready <= calm || $urandom_range(99) >= 22;
        if (m_tvalid && m_tready) begin
            got = '{m_tdata[1:0], m_tdata[17:2], m_tdata[18]};
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %p", got);
            end
            else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1500000) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [151:0] pack_request(input logic [1:0] op, input logic [11:0] px,
            input logic [12:0] na, nb, nc, nd, input logic [15:0] l0, l1, l2, l3,
            input logic [15:0] u, input logic [1:0] lab);
        return {4'b0, lab, u, l3, l2, l1, l0, nd, nc, nb, na, px, op};
    endfunction

    function automatic logic [12:0] rand_nbr(input int region);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 13'd4096;
        if (r < 20)
            return 13'($urandom_range(4096));
        return 13'($urandom_range(region - 1));
    endfunction

    function automatic logic [15:0] rand_ll(input logic [15:0] base);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return IMPOSSIBLE;
        if (r < 20)
            return 16'($urandom);
        return base + 16'($urandom_range(1535)) - 16'd768;
    endfunction

    function automatic logic [151:0] rand_request();
        logic [1:0]  op;
        logic [15:0] base;
        int          region;
        region = ($urandom_range(9) == 0) ? 4096 : 64;
        op = ($urandom_range(99) < 15) ? OP_WRITE : 2'($urandom_range(3, 1));
        base = 16'($urandom);
        if ($urandom_range(19) == 0)
            return pack_request(op, 12'($urandom), 13'd4096, rand_nbr(region),
                                rand_nbr(region), rand_nbr(region), IMPOSSIBLE, IMPOSSIBLE,
                                IMPOSSIBLE, rand_ll(base), 16'($urandom), 2'($urandom));
        return pack_request(op, 12'($urandom_range(region - 1)), rand_nbr(region),
                            rand_nbr(region), rand_nbr(region), rand_nbr(region),
                            rand_ll(base), rand_ll(base), rand_ll(base), rand_ll(base),
                            16'($urandom), 2'($urandom));
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() > 0 || s_tvalid || expected_samples.size() > 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_BETA)
            beta_reg = value;
        else
            prior_reg[idx - 1] = value;
    endtask

    task automatic set_config(input logic [15:0] b, p0, p1, p2, p3);
        apb_write(REG_BETA, b);
        apb_write(REG_PRIOR0, p0);
        apb_write(REG_PRIOR1, p1);
        apb_write(REG_PRIOR2, p2);
        apb_write(REG_PRIOR3, p3);
    endtask

    initial
    begin
        foreach (label_mem[i]) label_mem[i] = '0;
        foreach (visit_mem[i]) visit_mem[i] = '0;
        beta_reg = '0;
        prior_reg = '{4{16'h0}};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        set_config(16'h1000, 16'h0100, 16'hFF00, 16'h0000, 16'h0080);
        // directed
        pending_requests.push_back(pack_request(OP_WRITE, 12'd0, '0, '0, '0, '0, '0, '0, '0,
                                   '0, '0, 2'd3));
        pending_requests.push_back(pack_request(OP_WRITE, 12'd4095, '0, '0, '0, '0, '0, '0,
                                   '0, '0, '0, 2'd2));
        pending_requests.push_back(pack_request(OP_WRITE, 12'd1, '0, '0, '0, '0, '0, '0, '0,
                                   '0, '0, 2'd1));
        pending_requests.push_back(pack_request(OP_GIBBS, 12'd1, 13'd0, 13'd4095, 13'd1, 13'd4096,
                                   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0, 2'd0));
        pending_requests.push_back(pack_request(OP_GIBBS, 12'd1, 13'd0, 13'd4095, 13'd1, 13'd4096,
                                   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 2'd0));
        pending_requests.push_back(pack_request(OP_GIBBS, 12'd2, 13'd4096, 13'd4096, 13'd4096,
                                   13'd4096, IMPOSSIBLE, IMPOSSIBLE, IMPOSSIBLE, IMPOSSIBLE,
                                   16'h8000, 2'd0));
        pending_requests.push_back(pack_request(OP_CLASSIFY, 12'd4095, 13'd0, 13'd0, 13'd0, 13'd0,
                                   IMPOSSIBLE, IMPOSSIBLE, IMPOSSIBLE, IMPOSSIBLE,
                                   16'h1234, 2'd0));
        pending_requests.push_back(pack_request(OP_NODATA, 12'd4095, 13'd0, 13'd0, 13'd4095,
                                   13'd1, IMPOSSIBLE, IMPOSSIBLE, IMPOSSIBLE, IMPOSSIBLE,
                                   16'h7FFF, 2'd0));
        pending_requests.push_back(pack_request(OP_GIBBS, 12'd3, 13'd0, 13'd0, 13'd0, 13'd0,
                                   16'h7FFF, 16'h8001, 16'h7FFF, IMPOSSIBLE, 16'hC000, 2'd0));
        pending_requests.push_back(pack_request(OP_CLASSIFY, 12'd3, 13'd4096, 13'd4096, 13'd4096,
                                   13'd4096, 16'h8001, 16'h7FFF, 16'h0000, 16'h0100,
                                   16'hFFFF, 2'd0));
        pending_requests.push_back(pack_request(OP_CLASSIFY, 12'd5, 13'd4096, 13'd4096, 13'd4096,
                                   13'd4096, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 2'd0));
        pending_requests.push_back(pack_request(OP_NODATA, 12'd5, 13'd5, 13'd5, 13'd5, 13'd5,
                                   '0, '0, '0, '0, 16'hAAAA, 2'd0));
        for (int i = 0; i < 8; i++)
            pending_requests.push_back(pack_request(OP_GIBBS, 12'd6, 13'd6, 13'd7, 13'd6, 13'd7,
                                       16'h0000, 16'h0010, 16'hFFF0, IMPOSSIBLE,
                                       16'($urandom), 2'd0));
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
                1: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: set_config(16'h0001, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
                default: set_config(16'($urandom_range(16384)), 16'($urandom_range(1024)) - 16'd512,
                                    16'($urandom_range(1024)) - 16'd512, 16'($urandom),
                                    16'($urandom_range(1024)) - 16'd512);
            endcase
            calm = (phase == 2);
            for (int i = 0; i < 380; i++)
                pending_requests.push_back(rand_request());
            wait_drained();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
